[sv/gh_pkg.sv]
// Shared types, codes and defaults for the grid heat diffusion block.
// Depends on nothing; used by grid_heat_diffusion.
`timescale 1ns / 1ps
`default_nettype none
package gh_pkg;

  localparam int DEFAULT_GRID_SIDE = 64;

  localparam int TEMP_W  = 24;
  localparam int COORD_W = 6;
  localparam int SPREAD_W = 13;
  localparam int THRESH_W = 23;
  localparam int COUNT_W = 13;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_SET  = 2'd0;
  localparam cmd_t CMD_ADD  = 2'd1;
  localparam cmd_t CMD_STEP = 2'd2;
  localparam cmd_t CMD_READ = 2'd3;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SPREAD  = 2'd0;
  localparam reg_idx_t REG_ZERO_TH = 2'd1;
  localparam reg_idx_t REG_DEST_TH = 2'd2;

  localparam logic [SPREAD_W-1:0] SPREAD_RESET = 13'd2048;
  localparam logic [SPREAD_W-1:0] SPREAD_ONE   = 13'd4096;
  localparam logic [THRESH_W-1:0] ZERO_TH_RESET = 23'd205;
  localparam logic [THRESH_W-1:0] DEST_TH_RESET = 23'd8192;
  localparam logic [COUNT_W-1:0]  COUNT_MAX     = 13'd8191;

  localparam logic signed [40:0] TEMP_MAX_W = 41'sd8388607;
  localparam logic signed [40:0] TEMP_MIN_W = -41'sd8388608;

  // Saturate a wide signed value into the signed 24-bit temperature range.
  function automatic logic signed [TEMP_W-1:0] sat24(input logic signed [40:0] v);
    logic signed [TEMP_W-1:0] r;
    if (v > TEMP_MAX_W) begin
      r = 24'sh7FFFFF;
    end else if (v < TEMP_MIN_W) begin
      r = 24'sh800000;
    end else begin
      r = v[TEMP_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/gh_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module gh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/grid_heat_diffusion.sv]
// Top level of the grid heat diffusion block: command sequencer, shared
// multiplier and register port. Depends on gh_pkg and gh_ram.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// A command transaction is accepted at a rising edge with start high and busy
// low. Commands are set cell, add heat, read cell and diffusion step. Every
// command produces exactly one result, shown for one cycle with out_valid
// high; the receiver cannot hold it off, so it must take it in that cycle.
// Set cell writes the cell directly; add heat and read cell first read the
// cell. A diffusion step sweeps the grid twice: the first pass reads each
// cell and its four neighbours through the single read port of the cell
// memory, then runs two products through one shared multiplier and writes
// the rounded result to a second memory; the second pass commits the new
// values and clears the cells that are hotter than the destroy threshold.
// After reset the block clears the cell memory, one cell per cycle
// (all GRID_SIDE * GRID_SIDE cells, 4096 by default), and holds busy high
// meanwhile. Registers on the APB-style port may be written at any time but
// should only change while the block is idle. The next command may be given
// in the very cycle a result is strobed.
module grid_heat_diffusion #(
  parameter int GRID_SIDE = gh_pkg::DEFAULT_GRID_SIDE
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_command,
  input  wire logic [gh_pkg::COORD_W-1:0]   in_cell_x,
  input  wire logic [gh_pkg::COORD_W-1:0]   in_cell_y,
  input  wire logic                         in_cell_present,
  input  wire logic signed [gh_pkg::TEMP_W-1:0] in_heat_value,
  // result channel
  output logic                              out_valid,
  output logic [gh_pkg::COUNT_W-1:0]        out_removed_count,
  output logic                              out_read_present,
  output logic signed [gh_pkg::TEMP_W-1:0]  out_read_temperature,
  output logic                              out_heat_applied,
  // register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [3:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(GRID_SIDE);
  localparam int TW    = gh_pkg::TEMP_W;
  localparam int MW    = TW + 1;

  // Read taps of one cell in the first pass, in issue order.
  localparam logic [2:0] TAP_OWN   = 3'd0;
  localparam logic [2:0] TAP_WEST  = 3'd1;
  localparam logic [2:0] TAP_EAST  = 3'd2;
  localparam logic [2:0] TAP_NORTH = 3'd3;
  localparam logic [2:0] TAP_SOUTH = 3'd4;
  localparam logic [2:0] TAP_END   = 3'd5;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SET, S_ADD_RD, S_ADD_WR, S_RD_RD, S_RD_OUT,
    S_P1_RD, S_P1_MUL1, S_P1_MUL2, S_P1_WR, S_P2_RD, S_P2_WR
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0] idx_r, idx_nxt;
  logic [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [2:0]    k_r, k_nxt;
  logic signed [TW-1:0]   own_r, own_nxt;
  logic signed [TW+1:0]   nsum_r, nsum_nxt;
  logic signed [40:0]     acc_r, acc_nxt;
  logic [gh_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;

  gh_pkg::cmd_t cmd_r, cmd_nxt;
  logic [gh_pkg::COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic pres_r, pres_nxt;
  logic signed [TW-1:0] heat_r, heat_nxt;

  logic [gh_pkg::SPREAD_W-1:0] spread_r;
  logic [gh_pkg::THRESH_W-1:0] zth_r, dth_r;

  logic                       out_valid_nxt, out_pres_nxt, out_applied_nxt;
  logic [gh_pkg::COUNT_W-1:0] out_removed_nxt;
  logic signed [TW-1:0]       out_temp_nxt;

  // Memory ports.
  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [MW-1:0] m_wdata, m_rdata;
  logic          n_we;
  logic [TW-1:0] n_wdata, n_rdata;

  gh_ram #(.WIDTH(MW), .DEPTH(CELLS)) u_cells (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  gh_ram #(.WIDTH(TW), .DEPTH(CELLS)) u_next (
    .clk(clk), .we(n_we), .waddr(idx_r), .wdata(n_wdata),
    .raddr(idx_r), .rdata(n_rdata)
  );

  // Addressed cell of a set, add or read command.
  logic          on_grid;
  logic [AW-1:0] cmd_idx;
  assign on_grid = (32'(cx_r) < GRID_SIDE) && (32'(cy_r) < GRID_SIDE);
  assign cmd_idx = AW'(32'(cy_r) * 32'(GRID_SIDE) + 32'(cx_r));

  // Spread factor above one acts as one.
  logic [gh_pkg::SPREAD_W-1:0] f_eff;
  assign f_eff = (spread_r > gh_pkg::SPREAD_ONE) ? gh_pkg::SPREAD_ONE : spread_r;

  // The shared multiplier: own * (1 - f) first, neighbour sum * f second.
  logic signed [TW+1:0] mul_a;
  logic signed [13:0]   mul_b;
  logic signed [39:0]   prod;
  always_comb begin
    if (state_r == S_P1_MUL1) begin
      mul_a = (TW+2)'(own_r);
      mul_b = {1'b0, gh_pkg::SPREAD_W'(gh_pkg::SPREAD_ONE - f_eff)};
    end else begin
      mul_a = nsum_r;
      mul_b = {1'b0, f_eff};
    end
  end
  assign prod = mul_a * mul_b;

  // Which tap's data sits on the read port, and whether that neighbour exists.
  logic [2:0] tap_in;
  logic       tap_ok;
  assign tap_in = k_r - 3'd1;
  always_comb begin
    case (tap_in)
      TAP_OWN:   tap_ok = 1'b1;
      TAP_WEST:  tap_ok = (x_r != '0);
      TAP_EAST:  tap_ok = (x_r != XW'(GRID_SIDE - 1));
      TAP_NORTH: tap_ok = (y_r != '0);
      TAP_SOUTH: tap_ok = (y_r != XW'(GRID_SIDE - 1));
      default:   tap_ok = 1'b0;
    endcase
  end

  logic [AW-1:0] tap_addr;
  always_comb begin
    case (k_r)
      TAP_OWN:   tap_addr = idx_r;
      TAP_WEST:  tap_addr = idx_r - AW'(1);
      TAP_EAST:  tap_addr = idx_r + AW'(1);
      TAP_NORTH: tap_addr = idx_r - AW'(GRID_SIDE);
      TAP_SOUTH: tap_addr = idx_r + AW'(GRID_SIDE);
      default:   tap_addr = idx_r;
    endcase
  end

  // Rounded, saturated and thresholded new value of the current cell.
  logic signed [40:0] rounded;
  logic signed [TW-1:0] nv_sat, nv_final;
  assign rounded = (acc_r + 41'sd8192) >>> 14;
  assign nv_sat  = gh_pkg::sat24(rounded);
  assign nv_final = ($signed(nv_sat) <= $signed({1'b0, zth_r})) ? '0 : nv_sat;

  logic signed [TW-1:0] heat_sum;
  assign heat_sum = gh_pkg::sat24(41'($signed(m_rdata[TW-1:0])) + 41'(heat_r));

  logic last_cell, hot;
  logic [gh_pkg::COUNT_W-1:0] cnt_inc;
  assign last_cell = (idx_r == AW'(CELLS - 1));
  assign hot       = $signed(n_rdata) > $signed({1'b0, dth_r});
  assign cnt_inc   = (cnt_r == gh_pkg::COUNT_MAX) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    x_nxt = x_r;
    y_nxt = y_r;
    k_nxt = k_r;
    own_nxt = own_r;
    nsum_nxt = nsum_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    cmd_nxt = cmd_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    pres_nxt = pres_r;
    heat_nxt = heat_r;
    out_valid_nxt = 1'b0;
    out_removed_nxt = '0;
    out_pres_nxt = 1'b0;
    out_temp_nxt = '0;
    out_applied_nxt = 1'b0;
    m_we = 1'b0;
    m_waddr = idx_r;
    m_wdata = '0;
    m_raddr = idx_r;
    n_we = 1'b0;
    n_wdata = nv_final;

    case (state_r)
      S_CLEAR: begin
        m_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (last_cell) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_command;
          cx_nxt = in_cell_x;
          cy_nxt = in_cell_y;
          pres_nxt = in_cell_present;
          heat_nxt = in_heat_value;
          case (in_command)
            gh_pkg::CMD_SET:  state_nxt = S_SET;
            gh_pkg::CMD_ADD:  state_nxt = S_ADD_RD;
            gh_pkg::CMD_STEP: begin
              state_nxt = S_P1_RD;
              idx_nxt = '0;
              x_nxt = '0;
              y_nxt = '0;
              k_nxt = '0;
              cnt_nxt = '0;
            end
            default:          state_nxt = S_RD_RD;
          endcase
        end
      end
      S_SET: begin
        m_we = on_grid;
        m_waddr = cmd_idx;
        m_wdata = {pres_r, heat_r};
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ADD_RD: begin
        m_raddr = cmd_idx;
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        m_waddr = cmd_idx;
        m_wdata = {1'b1, heat_sum};
        m_we = on_grid && m_rdata[TW];
        out_applied_nxt = on_grid && m_rdata[TW];
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD_RD: begin
        m_raddr = cmd_idx;
        state_nxt = S_RD_OUT;
      end
      S_RD_OUT: begin
        out_pres_nxt = on_grid && m_rdata[TW];
        out_temp_nxt = on_grid ? $signed(m_rdata[TW-1:0]) : '0;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_P1_RD: begin
        m_raddr = tap_addr;
        if (k_r == TAP_OWN) begin
          nsum_nxt = '0;
        end else if (tap_in == TAP_OWN) begin
          own_nxt = $signed(m_rdata[TW-1:0]);
        end else if (tap_ok && m_rdata[TW]) begin
          nsum_nxt = nsum_r + (TW+2)'($signed(m_rdata[TW-1:0]));
        end
        k_nxt = k_r + 3'd1;
        if (k_r == TAP_END) begin
          state_nxt = S_P1_MUL1;
        end
      end
      S_P1_MUL1: begin
        acc_nxt = 41'(prod) <<< 2;
        state_nxt = S_P1_MUL2;
      end
      S_P1_MUL2: begin
        acc_nxt = acc_r + 41'(prod);
        state_nxt = S_P1_WR;
      end
      S_P1_WR: begin
        n_we = 1'b1;
        k_nxt = '0;
        if (last_cell) begin
          idx_nxt = '0;
          state_nxt = S_P2_RD;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_P1_RD;
          if (x_r == XW'(GRID_SIDE - 1)) begin
            x_nxt = '0;
            y_nxt = y_r + 1'b1;
          end else begin
            x_nxt = x_r + 1'b1;
          end
        end
      end
      S_P2_RD: begin
        state_nxt = S_P2_WR;
      end
      S_P2_WR: begin
        if (m_rdata[TW]) begin
          m_we = 1'b1;
          if (hot) begin
            m_wdata = '0;
            cnt_nxt = cnt_inc;
          end else begin
            m_wdata = {1'b1, n_rdata};
          end
        end
        if (last_cell) begin
          out_removed_nxt = cnt_nxt;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_P2_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r <= '0;
      k_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      k_r <= k_nxt;
      out_valid <= out_valid_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    own_r <= own_nxt;
    nsum_r <= nsum_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    cmd_r <= cmd_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    pres_r <= pres_nxt;
    heat_r <= heat_nxt;
    out_removed_count <= out_removed_nxt;
    out_read_present <= out_pres_nxt;
    out_read_temperature <= out_temp_nxt;
    out_heat_applied <= out_applied_nxt;
  end

  assign busy = (state_r != S_IDLE);

  // Register port: writes complete in the access phase, pready is tied high.
  logic     cfg_wr;
  gh_pkg::reg_idx_t cfg_sel;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_r <= gh_pkg::SPREAD_RESET;
      zth_r <= gh_pkg::ZERO_TH_RESET;
      dth_r <= gh_pkg::DEST_TH_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        gh_pkg::REG_SPREAD:  spread_r <= pwdata[gh_pkg::SPREAD_W-1:0];
        gh_pkg::REG_ZERO_TH: zth_r <= pwdata[gh_pkg::THRESH_W-1:0];
        gh_pkg::REG_DEST_TH: dth_r <= pwdata[gh_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      gh_pkg::REG_SPREAD:  prdata = 32'(spread_r);
      gh_pkg::REG_ZERO_TH: prdata = 32'(zth_r);
      gh_pkg::REG_DEST_TH: prdata = 32'(dth_r);
      default:             prdata = '0;
    endcase
  end

  // A result only follows work, so busy was high the cycle before it.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  // An accepted command makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // Only a diffusion step reports removed cells.
  a_removed_step_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cmd_r != gh_pkg::CMD_STEP) |-> (out_removed_count == '0))
    else $error("removed count from a non-step command");

  // Read and add-heat flags never appear together.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_read_present && out_heat_applied))
    else $error("read and heat flags both set");

endmodule
`default_nettype wire
